@@ rtl/cim_pkg.sv @@
package cim_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_PURGE  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_CONFLICT  = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_BAD_RANGE = 2'd3;

    typedef struct packed {
        logic load;
        logic lk_chk;
        logic scan;
        logic set_bad;
        logic set_conf;
        logic set_full;
        logic ins_prep;
        logic mrg_prep;
        logic mrg_start;
        logic rd_i;
        logic rd_im1;
        logic rd_ik;
        logic wr_mv;
        logic wr_new;
        logic inc_i;
        logic dec_i;
        logic cnt_inc;
        logic cnt_sub_k;
        logic pg_chk;
        logic pg_fin;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic i_end;
        logic lk_hit;
        logic lk_past;
        logic e_lt_s;
        logic e_eq_s;
        logic scan_stop;
        logic conflict;
        logic need_ins;
        logic full;
        logic i_gt_m0;
        logic mv_end;
    } t_sts;

endpackage

@@ rtl/cim_datapath.sv @@
module cim_datapath #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [63:0]     i_address,
    input  logic [63:0]     i_range_end,
    input  logic [15:0]     i_tag,
    input  cim_pkg::t_ctl   i_ctl,
    output cim_pkg::t_sts   o_sts,
    output logic            o_hit,
    output logic [15:0]     o_found_tag,
    output logic [1:0]      o_status
);
    import cim_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [63:0]         s;
        logic [63:0]         e;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    t_entry mem [CAPACITY];

    t_entry              r_q, r_e0, r_e1, r_l, r_pl;
    logic [63:0]         r_s, r_e;
    logic [TAG_BITS-1:0] r_t;
    logic [CW-1:0]       r_count, r_i, r_w, r_a, r_cnt, r_m0, r_k;
    logic                r_found_a, r_conflict;
    logic                r_hit, r_o_hit;
    logic [TAG_BITS-1:0] r_ftag;
    logic [15:0]         r_o_ftag;
    logic [1:0]          r_status, r_o_status;

    logic [TAG_BITS-1:0] t_in;
    logic [63:0]         ftag_ext;
    logic                in_range, q_end_ge_s;
    logic                df, dl;
    logic [CW-1:0]       rem, rem2, a_eff, m0, k;
    logic [63:0]         sm0, em1, new_s, new_e;
    logic [CW:0]         sum_ik;
    logic [CW-1:0]       im1;
    logic                rd_en, we;
    logic [IW-1:0]       rd_addr, wr_addr;
    t_entry              wr_data, new_ent;

    assign t_in     = TAG_BITS'({48'd0, i_tag});
    assign ftag_ext = 64'(r_ftag);

    assign q_end_ge_s = r_q.e >= r_s;
    assign in_range   = (r_found_a || q_end_ge_s) && (r_q.s <= r_e);

    assign df    = (r_cnt != '0) && (r_e0.e == r_s) && (r_e0.tag != r_t);
    assign rem   = r_cnt - CW'(df);
    assign dl    = (rem != '0) && (r_l.s == r_e) && (r_l.tag != r_t);
    assign rem2  = rem - CW'(dl);
    assign a_eff = r_found_a ? r_a : r_count;
    assign m0    = a_eff + CW'(df);
    assign k     = rem2 - CW'(1);
    assign sm0   = df ? r_e1.s : r_e0.s;
    assign em1   = dl ? r_pl.e : r_l.e;
    assign new_s = (sm0 < r_s) ? sm0 : r_s;
    assign new_e = (em1 > r_e) ? em1 : r_e;

    assign sum_ik = {1'b0, r_i} + {1'b0, r_k};
    assign im1    = r_i - CW'(1);

    always_comb begin
        o_sts           = '0;
        o_sts.i_end     = r_i == r_count;
        o_sts.lk_hit    = (r_s >= r_q.s) && (r_s < r_q.e);
        o_sts.lk_past   = r_q.s > r_s;
        o_sts.e_lt_s    = r_e < r_s;
        o_sts.e_eq_s    = r_e == r_s;
        o_sts.scan_stop = (r_found_a || q_end_ge_s) && (r_q.s > r_e);
        o_sts.conflict  = r_conflict;
        o_sts.need_ins  = rem2 == '0;
        o_sts.full      = r_count >= CW'(CAPACITY);
        o_sts.i_gt_m0   = r_i > r_m0;
        o_sts.mv_end    = (r_k == '0) || (sum_ik >= {1'b0, r_count});
    end

    always_comb begin
        new_ent.s   = r_s;
        new_ent.e   = r_e;
        new_ent.tag = r_t;
        rd_en   = i_ctl.rd_i || i_ctl.rd_im1 || i_ctl.rd_ik;
        rd_addr = r_i[IW-1:0];
        if (i_ctl.rd_im1) begin
            rd_addr = im1[IW-1:0];
        end else if (i_ctl.rd_ik) begin
            rd_addr = sum_ik[IW-1:0];
        end
        we      = 1'b0;
        wr_addr = r_i[IW-1:0];
        wr_data = r_q;
        if (i_ctl.wr_mv) begin
            we = 1'b1;
        end else if (i_ctl.wr_new) begin
            we      = 1'b1;
            wr_addr = r_m0[IW-1:0];
            wr_data = new_ent;
        end else if (i_ctl.pg_chk && (r_q.tag != r_t)) begin
            we      = 1'b1;
            wr_addr = r_w[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.cnt_sub_k) begin
            r_count <= r_count - r_k;
        end else if (i_ctl.pg_fin) begin
            r_count <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s        <= i_address;
            r_e        <= i_range_end;
            r_t        <= t_in;
            r_i        <= '0;
            r_w        <= '0;
            r_cnt      <= '0;
            r_found_a  <= 1'b0;
            r_conflict <= 1'b0;
            r_hit      <= 1'b0;
            r_ftag     <= '0;
            r_status   <= STS_OK;
        end else begin
            if (i_ctl.ins_prep) begin
                r_i <= r_count;
            end else if (i_ctl.mrg_start) begin
                r_i <= r_m0 + CW'(1);
            end else if (i_ctl.inc_i) begin
                r_i <= r_i + CW'(1);
            end else if (i_ctl.dec_i) begin
                r_i <= im1;
            end
            if (i_ctl.lk_chk && o_sts.lk_hit) begin
                r_hit  <= 1'b1;
                r_ftag <= r_q.tag;
            end
            if (i_ctl.scan) begin
                if (!r_found_a && q_end_ge_s) begin
                    r_found_a <= 1'b1;
                    r_a       <= r_i;
                end
                if (in_range) begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == '0) begin
                        r_e0 <= r_q;
                    end
                    if (r_cnt == CW'(1)) begin
                        r_e1 <= r_q;
                    end
                    r_l  <= r_q;
                    r_pl <= r_l;
                    if ((r_q.e > r_s) && (r_q.s < r_e) && (r_q.tag != r_t)) begin
                        r_conflict <= 1'b1;
                    end
                end
            end
            if (i_ctl.set_bad) begin
                r_status <= STS_BAD_RANGE;
            end else if (i_ctl.set_conf) begin
                r_status <= STS_CONFLICT;
            end else if (i_ctl.set_full) begin
                r_status <= STS_FULL;
            end
            if (i_ctl.ins_prep) begin
                r_m0 <= m0;
            end
            if (i_ctl.mrg_prep) begin
                r_m0 <= m0;
                r_k  <= k;
                r_s  <= new_s;
                r_e  <= new_e;
            end
            if (i_ctl.pg_chk && (r_q.tag != r_t)) begin
                r_w <= r_w + CW'(1);
            end
        end
        if (i_ctl.out_load) begin
            r_o_hit    <= r_hit;
            r_o_ftag   <= ftag_ext[15:0];
            r_o_status <= r_status;
        end
    end

    assign o_hit       = r_o_hit;
    assign o_found_tag = r_o_ftag;
    assign o_status    = r_o_status;

endmodule

@@ rtl/cim_control.sv @@
module cim_control (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [1:0]    i_op,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  cim_pkg::t_sts i_sts,
    output cim_pkg::t_ctl o_ctl
);
    import cim_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LK_RD, S_LK_CHK, S_ST_DEC, S_ST_RD, S_ST_CHK, S_ST_EVAL,
        S_INS_RD, S_INS_WR, S_INS_PUT, S_MRG_PUT, S_MRG_RD, S_MRG_WR,
        S_PG_RD, S_PG_CHK, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   accept;

    assign o_s_tready = r_state == S_IDLE;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_tready;
        o_ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctl.load = 1'b1;
                    unique case (i_op)
                        OP_LOOKUP: n_state = S_LK_RD;
                        OP_SET:    n_state = S_ST_DEC;
                        OP_PURGE:  n_state = S_PG_RD;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_LK_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_FINISH;
                end else begin
                    o_ctl.rd_i = 1'b1;
                    n_state    = S_LK_CHK;
                end
            end
            S_LK_CHK: begin
                o_ctl.lk_chk = 1'b1;
                o_ctl.inc_i  = 1'b1;
                n_state = (i_sts.lk_hit || i_sts.lk_past) ? S_FINISH : S_LK_RD;
            end
            S_ST_DEC: begin
                if (i_sts.e_lt_s) begin
                    o_ctl.set_bad = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_sts.e_eq_s) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_ST_RD;
                end
            end
            S_ST_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_ST_EVAL;
                end else begin
                    o_ctl.rd_i = 1'b1;
                    n_state    = S_ST_CHK;
                end
            end
            S_ST_CHK: begin
                o_ctl.scan  = 1'b1;
                o_ctl.inc_i = 1'b1;
                n_state = i_sts.scan_stop ? S_ST_EVAL : S_ST_RD;
            end
            S_ST_EVAL: begin
                if (i_sts.conflict) begin
                    o_ctl.set_conf = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_sts.need_ins) begin
                    if (i_sts.full) begin
                        o_ctl.set_full = 1'b1;
                        n_state        = S_FINISH;
                    end else begin
                        o_ctl.ins_prep = 1'b1;
                        n_state        = S_INS_RD;
                    end
                end else begin
                    o_ctl.mrg_prep = 1'b1;
                    n_state        = S_MRG_PUT;
                end
            end
            S_INS_RD: begin
                if (i_sts.i_gt_m0) begin
                    o_ctl.rd_im1 = 1'b1;
                    n_state      = S_INS_WR;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_WR: begin
                o_ctl.wr_mv = 1'b1;
                o_ctl.dec_i = 1'b1;
                n_state     = S_INS_RD;
            end
            S_INS_PUT: begin
                o_ctl.wr_new  = 1'b1;
                o_ctl.cnt_inc = 1'b1;
                n_state       = S_FINISH;
            end
            S_MRG_PUT: begin
                o_ctl.wr_new    = 1'b1;
                o_ctl.mrg_start = 1'b1;
                n_state         = S_MRG_RD;
            end
            S_MRG_RD: begin
                if (i_sts.mv_end) begin
                    o_ctl.cnt_sub_k = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_ctl.rd_ik = 1'b1;
                    n_state     = S_MRG_WR;
                end
            end
            S_MRG_WR: begin
                o_ctl.wr_mv = 1'b1;
                o_ctl.inc_i = 1'b1;
                n_state     = S_MRG_RD;
            end
            S_PG_RD: begin
                if (i_sts.i_end) begin
                    o_ctl.pg_fin = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_ctl.rd_i = 1'b1;
                    n_state    = S_PG_CHK;
                end
            end
            S_PG_CHK: begin
                o_ctl.pg_chk = 1'b1;
                o_ctl.inc_i  = 1'b1;
                n_state      = S_PG_RD;
            end
            S_FINISH: begin
                if (!r_m_valid || i_m_tready) begin
                    o_ctl.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

@@ rtl/coalescing_interval_map.sv @@
// Sorted table of up to CAPACITY disjoint half-open ranges, each with a tag,
// held in a single-port memory with registered read data. One request is
// processed at a time; the finished result sits in an output register, so a
// new request is taken while the previous result waits. Every table entry
// touched costs a memory read, then a check or write. A lookup scans from
// the lowest entry up to the one holding or passing the address, or through
// every entry when every entry lies below the address. A set scans up to
// the end of the affected entries, then shifts the tail of the table by one
// place (insert) or closes the gap left by merged entries. A purge reads
// every entry once. Statuses on the result: 0 ok, 1 tag conflict, 2 table
// full, 3 end before start; a failed set leaves the table unchanged.
module coalescing_interval_map #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,  // address[63:0], range_end[127:64], tag[143:128]
    input  logic [1:0]   i_s_tuser,  // op[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [23:0]  o_m_tdata   // hit[0], found_tag[16:1], status[18:17], zero
);
    import cim_pkg::*;

    t_ctl        ctl;
    t_sts        sts;
    logic        hit;
    logic [15:0] found_tag;
    logic [1:0]  status;

    cim_control u_control (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    cim_datapath #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_address   (i_s_tdata[63:0]),
        .i_range_end (i_s_tdata[127:64]),
        .i_tag       (i_s_tdata[143:128]),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_hit       (hit),
        .o_found_tag (found_tag),
        .o_status    (status)
    );

    assign o_m_tdata = {5'd0, status, found_tag, hit};

endmodule
